// ===== sv/itda_pkg.sv =====
// Shared types, constants and the double-dabble step for the integer-to-ASCII unit.
// No dependencies; used by the controller, the datapath and the top level.

package itda_pkg;

   localparam int ValueWidth  = 32;
   localparam int CharWidth   = 8;
   localparam int NumDigits   = 10;
   localparam int DigitWidth  = 4;
   localparam int IdxWidth    = $clog2(NumDigits);
   localparam int BitsPerStep = 4;
   localparam int ConvSteps   = ValueWidth / BitsPerStep;
   localparam int StepWidth   = $clog2(ConvSteps);

   localparam logic [CharWidth-1:0] CharZero  = 8'd48;
   localparam logic [CharWidth-1:0] CharMinus = 8'd45;

   typedef logic [NumDigits-1:0][DigitWidth-1:0] bcd_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;       // capture the input and form its magnitude
      logic step;       // shift BitsPerStep magnitude bits into the BCD register
      logic lead;       // point the digit index at the leading nonzero digit
      logic advance;    // move to the next lower digit
      logic emit_sign;  // present '-' instead of a digit
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic neg;
      logic idx_zero;
   } status_type;

   // One double-dabble bit: add 3 to every digit of 5 or more, then shift in bit_in.
   function automatic bcd_type dabble_bit(input bcd_type bcd, input logic bit_in);
      bcd_type adj;
      adj = bcd;
      for (int i = 0; i < NumDigits; i++) begin
         if (bcd[i] >= 4'd5) begin
            adj[i] = bcd[i] + 4'd3;
         end
      end
      return bcd_type'({adj, bit_in});
   endfunction

endpackage

// ===== sv/itda_datapath.sv =====
// Datapath of the integer-to-ASCII unit: magnitude, BCD conversion and digit select.
// Depends on itda_pkg.

module itda_datapath (
   input  logic                            clock,
   input  itda_pkg::cmd_type               cmd,
   input  logic [itda_pkg::ValueWidth-1:0] value,
   output itda_pkg::status_type            status,
   output logic [itda_pkg::CharWidth-1:0]  ch,
   output logic                            last
);

   logic [itda_pkg::ValueWidth-1:0] bin_ff, bin_in;
   itda_pkg::bcd_type               bcd_ff, bcd_in;
   logic                            neg_ff, neg_in;
   logic [itda_pkg::IdxWidth-1:0]   idx_ff, idx_in;
   logic [itda_pkg::IdxWidth-1:0]   lead_idx;
   itda_pkg::bcd_type               bcd_step;

   // Four chained dabble bits, MSB of the remaining magnitude first.
   always_comb begin
      bcd_step = bcd_ff;
      for (int b = 0; b < itda_pkg::BitsPerStep; b++) begin
         bcd_step = itda_pkg::dabble_bit(bcd_step, bin_ff[itda_pkg::ValueWidth-1-b]);
      end
   end

   // Highest nonzero digit; zero maps to the units digit.
   always_comb begin
      lead_idx = '0;
      for (int i = 0; i < itda_pkg::NumDigits; i++) begin
         if (bcd_ff[i] != '0) begin
            lead_idx = itda_pkg::IdxWidth'(i);
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      neg_in = neg_ff;
      idx_in = idx_ff;
      if (cmd.load) begin
         neg_in = value[itda_pkg::ValueWidth-1];
         bin_in = value[itda_pkg::ValueWidth-1] ? (~value + 1'b1) : value;
         bcd_in = '0;
      end
      if (cmd.step) begin
         bcd_in = bcd_step;
         bin_in = bin_ff << itda_pkg::BitsPerStep;
      end
      if (cmd.lead) begin
         idx_in = lead_idx;
      end
      if (cmd.advance) begin
         idx_in = idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
      idx_ff <= idx_in;
   end

   assign status.neg      = neg_ff;
   assign status.idx_zero = (idx_ff == '0);

   assign ch   = cmd.emit_sign ? itda_pkg::CharMinus
                               : itda_pkg::CharZero + itda_pkg::CharWidth'(bcd_ff[idx_ff]);
   assign last = !cmd.emit_sign && (idx_ff == '0);

endmodule

// ===== sv/itda_controller.sv =====
// Sequencing state machine of the integer-to-ASCII unit.
// Depends on itda_pkg; drives the datapath through cmd_type and reads status_type.

module itda_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  itda_pkg::status_type  status,
   output itda_pkg::cmd_type     cmd
);

   typedef enum logic [4:0] {
      StIdle   = 5'b00001,
      StConv   = 5'b00010,
      StLead   = 5'b00100,
      StSign   = 5'b01000,
      StDigits = 5'b10000
   } state_type;

   state_type                      state_ff, state_in;
   logic [itda_pkg::StepWidth-1:0] step_ff, step_in;
   logic                           req_xfer;
   logic                           rsp_xfer;

   assign req_tready = (state_ff == StIdle);
   assign rsp_tvalid = (state_ff == StSign) || (state_ff == StDigits);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd           = '0;
      cmd.emit_sign = (state_ff == StSign);
      unique case (state_ff)
         StIdle: begin
            if (req_xfer) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = StConv;
            end
         end
         StConv: begin
            cmd.step = 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == itda_pkg::StepWidth'(itda_pkg::ConvSteps - 1)) begin
               state_in = StLead;
            end
         end
         StLead: begin
            cmd.lead = 1'b1;
            state_in = status.neg ? StSign : StDigits;
         end
         StSign: begin
            if (rsp_xfer) begin
               state_in = StDigits;
            end
         end
         StDigits: begin
            if (rsp_xfer) begin
               if (status.idx_zero) begin
                  state_in = StIdle;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while a character is pending");

   a_accept_converts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == StConv) && (step_ff == '0))
      else $error("accepted item did not start conversion");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StDigits) && rsp_xfer && status.idx_zero |=> req_tready)
      else $error("unit not idle after the final character");

   a_conv_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StLead) |-> $past(state_ff) == StConv)
      else $error("leading digit search without conversion");

endmodule

// ===== sv/int_to_decimal_ascii_unit.sv =====
// Signed 32-bit integer to decimal ASCII, one character per transfer, MSB first.
// The first character is valid once the conversion is done: 8 conversion steps of
// 4 bits each through the double-dabble unit, then the leading-digit search.
// N = 1..11 characters, one character a cycle unless the sink stalls; next input waits.
// Reset: synchronous, active high; returns the controller to idle, drops any pending text.
// Depends on itda_pkg, itda_controller and itda_datapath.

module int_to_decimal_ascii_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value (signed)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] ch
   output logic        rsp_tlast    // last character of this number
);

   itda_pkg::cmd_type    cmd;
   itda_pkg::status_type status;

   // Controller: accepts one number, runs the conversion steps, then walks the
   // characters out, holding each until its transfer completes.
   itda_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: magnitude register, BCD register and digit index. The character
   // comes straight from registered state, so it holds while the sink stalls.
   itda_datapath u_dp (
      .clock  (clock),
      .cmd    (cmd),
      .value  (req_tdata),
      .status (status),
      .ch     (rsp_tdata),
      .last   (rsp_tlast)
   );

endmodule
